// ----- sv/pfba_pkg.sv -----
`default_nettype none
// pfba_pkg: shared constants, command codes and controller state type
// for the paged fixed-block allocator; no dependencies
package pfba_pkg;

  localparam int ADDR_W = 17;
  localparam int PA_W = 3;
  localparam int DEF_BLOCKS_PER_PAGE = 1024;
  localparam int DEF_BLOCK_BYTES = 32;
  localparam int DEF_PAGE_SLOTS = 4;
  localparam int MAX_WORD_BITS = 32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_OUT
  } pfba_state_t;

endpackage
`default_nettype wire

// ----- sv/paged_fixed_block_allocator_top.sv -----
`default_nettype none
// paged fixed-block allocator: one request in, one result out; each request
// passes accept, bitmap read, read-modify-write (skipped when no slot or
// active page is found) and result, in that order; next request accepted
// once the result transfer completes. reset: slot 0 active, all counts zero,
// every block free (bitmap rows read as all ones until first written)
module paged_fixed_block_allocator_top
  import pfba_pkg::*;
#(
  parameter int BLOCKS_PER_PAGE = DEF_BLOCKS_PER_PAGE,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int PAGE_SLOTS = DEF_PAGE_SLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              cmd,
  input  wire logic [ADDR_W-1:0] addr,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   ok,
  output logic      [ADDR_W-1:0] block_addr,
  output logic      [PA_W-1:0]   pages_active
);

  // bitmap geometry: words of up to 32 block-free bits
  localparam int WORD_BITS = (BLOCKS_PER_PAGE < MAX_WORD_BITS) ? BLOCKS_PER_PAGE
                                                               : MAX_WORD_BITS;
  localparam int WORD_SH = $clog2(WORD_BITS);
  localparam int WPP = BLOCKS_PER_PAGE / WORD_BITS;
  localparam int WORDS = PAGE_SLOTS * WPP;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SLOT_W = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int CNT_W = $clog2(BLOCKS_PER_PAGE + 1);
  localparam int BLK_SH = $clog2(BLOCK_BYTES);
  localparam int PAGE_SH = $clog2(BLOCKS_PER_PAGE) + BLK_SH;

  pfba_state_t state, state_next;

  logic                  cmd_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [PAGE_SLOTS-1:0] active;
  logic [CNT_W-1:0]      used_cnt [PAGE_SLOTS];
  // per-word summary: set when a bitmap word holds no free block
  logic [WORDS-1:0]      word_full;
  logic [SLOT_W-1:0]     slot_r;
  logic [WIDX_W-1:0]     widx_r;
  logic [WORD_SH-1:0]    bit_r;
  logic                  ok_r;
  logic [ADDR_W-1:0]     baddr_r;

  // search results while in the read cycle
  logic                  alloc_hit;
  logic [SLOT_W-1:0]     alloc_slot;
  logic [WIDX_W-1:0]     alloc_widx;
  logic                  free_hit;
  logic [SLOT_W-1:0]     free_slot;
  logic [WIDX_W-1:0]     free_widx;
  logic [WORD_SH-1:0]    free_bit;
  logic [31:0]           free_slot_wide;
  logic [31:0]           free_blk_wide;

  // modify-cycle signals
  logic [WORD_BITS-1:0]  rd_data;
  logic [WORD_BITS-1:0]  wr_data;
  logic                  wr_en;
  logic                  rd_en;
  logic [WIDX_W-1:0]     rd_idx;
  logic [WORD_SH-1:0]    pick_bit;
  logic [CNT_W-1:0]      dec_cnt;
  logic [31:0]           alloc_baddr;

  logic [PA_W-1:0]       act_count;

  pfba_bitmap_mem #(
    .WORDS(WORDS),
    .WORD_BITS(WORD_BITS),
    .WIDX_W(WIDX_W)
  ) u_mem (
    .clk(clk),
    .rst(rst),
    .rd_en(rd_en),
    .rd_idx(rd_idx),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_idx(widx_r),
    .wr_data(wr_data)
  );

  // alloc: first active slot with room, else lowest inactive slot;
  // then first word of that slot whose summary says it has a free block
  always_comb begin
    logic avail_hit, idle_hit, word_hit;
    logic [SLOT_W-1:0] avail_slot, idle_slot;
    logic [WIDX_W-1:0] wsel;
    avail_hit = 1'b0;
    idle_hit = 1'b0;
    word_hit = 1'b0;
    avail_slot = '0;
    idle_slot = '0;
    wsel = '0;
    for (int s = 0; s < PAGE_SLOTS; s++) begin
      if (!avail_hit && active[s] && (32'(used_cnt[s]) < 32'(BLOCKS_PER_PAGE))) begin
        avail_hit = 1'b1;
        avail_slot = SLOT_W'(s);
      end
      if (!idle_hit && !active[s]) begin
        idle_hit = 1'b1;
        idle_slot = SLOT_W'(s);
      end
    end
    alloc_hit = avail_hit || idle_hit;
    alloc_slot = avail_hit ? avail_slot : idle_slot;
    for (int w = 0; w < WPP; w++) begin
      if (!word_hit && !word_full[32'(alloc_slot) * WPP + w]) begin
        word_hit = 1'b1;
        wsel = WIDX_W'(w);
      end
    end
    alloc_widx = WIDX_W'(32'(alloc_slot) * WPP + 32'(wsel));
  end

  // free: slot and block straight from the offset
  always_comb begin
    free_slot_wide = 32'(addr_r) >> PAGE_SH;
    free_blk_wide = 32'(addr_r) >> BLK_SH;
    free_slot = free_slot_wide[SLOT_W-1:0];
    free_hit = (free_slot_wide < 32'(PAGE_SLOTS)) && active[free_slot];
    free_widx = WIDX_W'(free_blk_wide >> WORD_SH);
    free_bit = free_blk_wide[WORD_SH-1:0];
  end

  // first free bit of the word read back
  always_comb begin
    logic found;
    found = 1'b0;
    pick_bit = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!found && rd_data[b]) begin
        found = 1'b1;
        pick_bit = WORD_SH'(b);
      end
    end
  end

  assign dec_cnt = (used_cnt[slot_r] != '0) ? used_cnt[slot_r] - CNT_W'(1) : '0;
  assign alloc_baddr = ((32'(widx_r) << WORD_SH) | 32'(pick_bit)) << BLK_SH;

  always_comb begin
    if (cmd_r == CMD_ALLOC) begin
      wr_data = rd_data & ~(WORD_BITS'(1) << pick_bit);
      wr_en = (state == ST_MOD);
    end else begin
      wr_data = rd_data | (WORD_BITS'(1) << bit_r);
      wr_en = (state == ST_MOD) && !rd_data[bit_r];
    end
  end

  assign rd_idx = (cmd_r == CMD_ALLOC) ? alloc_widx : free_widx;

  // controller next state and handshake
  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    out_valid = 1'b0;
    rd_en = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (cmd_r == CMD_ALLOC) begin
          rd_en = alloc_hit;
          state_next = alloc_hit ? ST_MOD : ST_OUT;
        end else begin
          rd_en = free_hit;
          state_next = free_hit ? ST_MOD : ST_OUT;
        end
      end
      ST_MOD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r <= cmd;
          addr_r <= addr;
        end
      end
      ST_READ: begin
        ok_r <= 1'b0;
        baddr_r <= '0;
        if (cmd_r == CMD_ALLOC) begin
          slot_r <= alloc_slot;
          widx_r <= alloc_widx;
        end else begin
          slot_r <= free_slot;
          widx_r <= free_widx;
          bit_r <= free_bit;
        end
      end
      ST_MOD: begin
        ok_r <= 1'b1;
        if (cmd_r == CMD_ALLOC) begin
          baddr_r <= alloc_baddr[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // page state and word summary
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= PAGE_SLOTS'(1);
      word_full <= '0;
      for (int s = 0; s < PAGE_SLOTS; s++) begin
        used_cnt[s] <= '0;
      end
    end else if (state == ST_MOD) begin
      if (cmd_r == CMD_ALLOC) begin
        active[slot_r] <= 1'b1;
        used_cnt[slot_r] <= used_cnt[slot_r] + CNT_W'(1);
        word_full[widx_r] <= (wr_data == '0);
      end else if (!rd_data[bit_r]) begin
        used_cnt[slot_r] <= dec_cnt;
        word_full[widx_r] <= 1'b0;
        if ((slot_r != '0) && (dec_cnt == '0)) begin
          active[slot_r] <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    act_count = '0;
    for (int s = 0; s < PAGE_SLOTS; s++) begin
      act_count = act_count + PA_W'(active[s]);
    end
  end

  assign ok = ok_r;
  assign block_addr = baddr_r;
  assign pages_active = act_count;

endmodule
`default_nettype wire

// ----- sv/pfba_bitmap_mem.sv -----
`default_nettype none
// pfba_bitmap_mem: block-free bitmap, one word per row, registered read
// unwritten rows read as all ones; uses pfba_pkg
module pfba_bitmap_mem
  import pfba_pkg::*;
#(
  parameter int WORDS = 128,
  parameter int WORD_BITS = MAX_WORD_BITS,
  parameter int WIDX_W = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [WIDX_W-1:0]    rd_idx,
  output logic      [WORD_BITS-1:0] rd_data,
  input  wire logic                 wr_en,
  input  wire logic [WIDX_W-1:0]    wr_idx,
  input  wire logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     written;
  logic [WORD_BITS-1:0] rd_raw;
  logic                 rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= written[rd_idx];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '1;

endmodule
`default_nettype wire
